[rtl/iss_pkg.sv]
// Shared types for the integer set store: request and response payloads,
// the action codes and the control bundle broadcast to the storage cells.
// No dependencies.
package iss_pkg;

    // Request action codes.
    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    // One request item.
    typedef struct packed {
        action_t            action;
        logic signed [31:0] value;
    } req_t;

    // One response item.
    typedef struct packed {
        logic       success;
        logic [6:0] element_count;
        logic       is_empty;
        logic       is_full;
    } rsp_t;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic cmp_en;   // capture the membership compare
        logic insert;   // qualified append: the cell at the fill position loads
        logic remove;   // qualified delete: cells at or above the hit shift down
    } iss_cell_ctrl_t;

endpackage

[rtl/iss_stream_if.sv]
// Valid/ready stream channel carrying one payload per transfer.
// Depends on nothing; the payload type is a parameter.
interface iss_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/iss_cell.sv]
// One storage cell of the set: holds one entry, compares it with the probe
// value and takes its right neighbor's entry when a remove closes a gap.
// Depends on iss_pkg.
module iss_cell
    import iss_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int INDEX = 0,
    localparam int CNT_W = $clog2(CAPACITY + 1),
    localparam int IDX_W = $clog2(CAPACITY)
) (
    input  logic                 clk,
    input  iss_cell_ctrl_t       ctrl,
    input  logic [31:0]          probe,
    input  logic [31:0]          right_entry,
    input  logic [CNT_W-1:0]     count,
    input  logic [IDX_W-1:0]     hit_idx,
    output logic [31:0]          entry,
    output logic                 hit
);

    localparam logic [CNT_W-1:0] MY_POS = CNT_W'(INDEX);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [31:0] entry_reg;
    logic        hit_reg;
    logic        occupied;
    logic        load;
    logic        shift;

    // Position-based decode against the shared count and hit index.
    assign occupied = MY_POS < count;
    assign load     = ctrl.insert && (count == MY_POS);
    assign shift    = ctrl.remove && (MY_IDX >= hit_idx);

    // Entry storage: append at the fill position, or shift down on remove.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            entry_reg <= probe;
        end
        else if (shift)
        begin
            entry_reg <= right_entry;
        end
    end

    // Registered membership compare.
    always_ff @(posedge clk)
    begin
        if (ctrl.cmp_en)
        begin
            hit_reg <= occupied && (entry_reg == probe);
        end
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

[rtl/iss_hit_encoder.sv]
// Registered reduction of the per-cell hit vector into a found flag and the
// binary position of the matching cell. Depends on iss_pkg.
module iss_hit_encoder
    import iss_pkg::*;
#(
    parameter int CAPACITY = 64,
    localparam int IDX_W = $clog2(CAPACITY)
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [CAPACITY-1:0]  hits,
    output logic                 found,
    output logic [IDX_W-1:0]     hit_idx
);

    logic [IDX_W-1:0] idx_next;
    logic [IDX_W-1:0] hit_idx_reg;
    logic             found_reg;

    // At most one cell matches, so each index bit is an OR of the hits
    // at positions that carry that bit.
    for (genvar b = 0; b < IDX_W; b++)
    begin : g_bit
        logic [CAPACITY-1:0] sel;
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_pos
            localparam logic [IDX_W-1:0] POS = IDX_W'(i);
            assign sel[i] = hits[i] & POS[b];
        end
        assign idx_next[b] = |sel;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            found_reg   <= |hits;
            hit_idx_reg <= idx_next;
        end
    end

    assign found   = found_reg;
    assign hit_idx = hit_idx_reg;

endmodule

[rtl/integer_set_store_core.sv]
// Integer set store: a set of distinct 32-bit values kept in insertion order
// in a row of CAPACITY storage cells.
//
// Channels: req (sink) carries an action and a value; rsp (source) carries
// success, element_count, is_empty and is_full. A transfer happens on a
// rising clock edge with valid and ready both high. Every request gives
// exactly one response.
//
// Timing: the block works on one request at a time. An accepted request goes
// through compare in every cell, hit reduction, then update and response
// register, after which its response is valid. The next request is accepted
// once the block is back in idle after the update; the three-step compare,
// reduce and update sequence sets how often requests can be taken.
//
// A finished response sits in an output register. If the receiver stalls,
// the block still accepts and evaluates the next request and waits in the
// update step until the output register is free.
//
// Reset empties the set (count to zero); entry contents are not cleared and
// need no clearing pass.
module integer_set_store_core
    import iss_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    iss_stream_if.sink    req,
    iss_stream_if.source  rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_RES,
        ST_APPLY
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;
    rsp_t             rsp_reg, rsp_next;
    req_t             req_reg;

    logic                 req_fire;
    logic                 apply_fire;
    logic                 found;
    logic [IDX_W-1:0]     hit_idx;
    logic [CAPACITY-1:0]  hits;
    logic [31:0]          entries [CAPACITY];
    logic                 ok;
    logic                 do_insert;
    logic                 do_remove;
    logic [CNT_W+6:0]     count_ext;
    iss_cell_ctrl_t       cell_ctrl;

    assign req_fire   = req.valid && req.ready;
    assign apply_fire = (state_reg == ST_APPLY) && (!out_valid_reg || rsp.ready);

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            req_reg <= req.payload;
        end
    end

    // Qualified update operations.
    assign do_insert = (req_reg.action == ACT_INSERT) && !found && (count_reg < FULL_COUNT);
    assign do_remove = (req_reg.action == ACT_REMOVE) && found;

    assign cell_ctrl.cmp_en = (state_reg == ST_CMP);
    assign cell_ctrl.insert = apply_fire && do_insert;
    assign cell_ctrl.remove = apply_fire && do_remove;

    // Row of storage cells; each takes its right neighbor's entry on remove.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [31:0] right_entry;
        if (i == CAPACITY - 1)
        begin : g_last
            assign right_entry = entries[i];
        end
        else
        begin : g_inner
            assign right_entry = entries[i + 1];
        end

        iss_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (i)
        ) u_cell (
            .clk         (clk),
            .ctrl        (cell_ctrl),
            .probe       (req_reg.value),
            .right_entry (right_entry),
            .count       (count_reg),
            .hit_idx     (hit_idx),
            .entry       (entries[i]),
            .hit         (hits[i])
        );
    end

    // Hit reduction.
    iss_hit_encoder #(
        .CAPACITY (CAPACITY)
    ) u_hit_encoder (
        .clk     (clk),
        .en      (state_reg == ST_RES),
        .hits    (hits),
        .found   (found),
        .hit_idx (hit_idx)
    );

    // Sequencer next state, count update and response formation.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        rsp_next       = rsp_reg;
        ok             = 1'b0;
        count_ext      = '0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_RES;
            end
            ST_RES:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (apply_fire)
                begin
                    case (req_reg.action)
                        ACT_INSERT:
                        begin
                            ok = do_insert;
                            if (do_insert)
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        ACT_REMOVE:
                        begin
                            ok = do_remove;
                            if (do_remove)
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        ACT_QUERY:
                        begin
                            ok = found;
                        end
                        default:
                        begin
                            ok         = 1'b1;
                            count_next = '0;
                        end
                    endcase
                    count_ext              = {7'd0, count_next};
                    rsp_next.success       = ok;
                    rsp_next.element_count = count_ext[6:0];
                    rsp_next.is_empty      = (count_next == '0);
                    rsp_next.is_full       = (count_next == FULL_COUNT);
                    out_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, count and registered response.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign req.ready   = (state_reg == ST_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = rsp_reg;

    // Values are distinct, so at most one cell can match.
    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RES) |-> $onehot0(hits))
        else $error("more than one cell matched the probe value");

    // The count never exceeds the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("element count above capacity");

    // The count changes only in the update step.
    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_APPLY) |=> $stable(count_reg))
        else $error("element count changed outside the update step");

    // With the output register free, the response is seen valid once the
    // compare, reduction and update steps have run after the request transfer.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && !out_valid_reg) |-> ##4 rsp.valid)
        else $error("response did not appear four edges after the request");

endmodule
